// ===== rtl/core/prcc_pkg.sv =====
`default_nettype none

package prcc_pkg;

	localparam int NUM_CORNERS     = 4;
	localparam int CFG_INDEX_WIDTH = 4;

	// register indexes of the corner file
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER0_X = 4'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER0_Y = 4'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER1_X = 4'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER1_Y = 4'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER2_X = 4'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER2_Y = 4'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER3_X = 4'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORNER3_Y = 4'd7;

	typedef struct packed {
		logic                       en;
		logic [CFG_INDEX_WIDTH-1:0] index;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/prcc_cfg_regs.sv =====
`default_nettype none

module prcc_cfg_regs #(
	parameter int COORD_WIDTH = 17
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire prcc_pkg::cfg_wr_t        wr,
	input  wire        [COORD_WIDTH-1:0]  data,
	output logic signed [COORD_WIDTH-1:0] corner_x [prcc_pkg::NUM_CORNERS],
	output logic signed [COORD_WIDTH-1:0] corner_y [prcc_pkg::NUM_CORNERS]
);
	import prcc_pkg::*;

	logic signed [COORD_WIDTH-1:0] corner_x_q [NUM_CORNERS];
	logic signed [COORD_WIDTH-1:0] corner_y_q [NUM_CORNERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORNERS; i++) begin
				corner_x_q[i] <= '0;
				corner_y_q[i] <= '0;
			end
		end else if (wr.en) begin
			case (wr.index)
				CFG_CORNER0_X: corner_x_q[0] <= data;
				CFG_CORNER0_Y: corner_y_q[0] <= data;
				CFG_CORNER1_X: corner_x_q[1] <= data;
				CFG_CORNER1_Y: corner_y_q[1] <= data;
				CFG_CORNER2_X: corner_x_q[2] <= data;
				CFG_CORNER2_Y: corner_y_q[2] <= data;
				CFG_CORNER3_X: corner_x_q[3] <= data;
				CFG_CORNER3_Y: corner_y_q[3] <= data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign corner_x = corner_x_q;
	assign corner_y = corner_y_q;

endmodule

`default_nettype wire

// ===== rtl/core/prcc_side_mul.sv =====
`default_nettype none

module prcc_side_mul #(
	parameter int COORD_WIDTH = 17,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * DW
) (
	input  wire                           clk,
	input  wire                           load,
	input  wire signed  [COORD_WIDTH-1:0] c_x,
	input  wire signed  [COORD_WIDTH-1:0] c_y,
	input  wire signed  [COORD_WIDTH-1:0] d_x,
	input  wire signed  [COORD_WIDTH-1:0] d_y,
	input  wire signed  [COORD_WIDTH-1:0] a_x,
	input  wire signed  [COORD_WIDTH-1:0] a_y,
	input  wire signed  [COORD_WIDTH-1:0] b_x,
	input  wire signed  [COORD_WIDTH-1:0] b_y,
	output logic signed [PW-1:0]          prod_a_xy_s2,
	output logic signed [PW-1:0]          prod_a_yx_s2,
	output logic signed [PW-1:0]          prod_b_xy_s2,
	output logic signed [PW-1:0]          prod_b_yx_s2
);

	logic signed [DW-1:0] u_x, u_y;
	logic signed [DW-1:0] va_x, va_y, vb_x, vb_y;

	// side direction d-c, and each endpoint relative to d
	assign u_x  = {d_x[COORD_WIDTH-1], d_x} - {c_x[COORD_WIDTH-1], c_x};
	assign u_y  = {d_y[COORD_WIDTH-1], d_y} - {c_y[COORD_WIDTH-1], c_y};
	assign va_x = {a_x[COORD_WIDTH-1], a_x} - {d_x[COORD_WIDTH-1], d_x};
	assign va_y = {a_y[COORD_WIDTH-1], a_y} - {d_y[COORD_WIDTH-1], d_y};
	assign vb_x = {b_x[COORD_WIDTH-1], b_x} - {d_x[COORD_WIDTH-1], d_x};
	assign vb_y = {b_y[COORD_WIDTH-1], b_y} - {d_y[COORD_WIDTH-1], d_y};

	always_ff @(posedge clk) begin
		if (load) begin
			prod_a_xy_s2 <= u_x * va_y;
			prod_a_yx_s2 <= u_y * va_x;
			prod_b_xy_s2 <= u_x * vb_y;
			prod_b_yx_s2 <= u_y * vb_x;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/prcc_side_sign.sv =====
`default_nettype none

module prcc_side_sign #(
	parameter int COORD_WIDTH = 17,
	localparam int PW = 2 * (COORD_WIDTH + 1)
) (
	input  wire signed [PW-1:0] prod_a_xy,
	input  wire signed [PW-1:0] prod_a_yx,
	input  wire signed [PW-1:0] prod_b_xy,
	input  wire signed [PW-1:0] prod_b_yx,
	output logic                hit
);

	logic signed [PW:0] cross_a, cross_b;
	logic               pos_a, pos_b, zero_a, zero_b;

	assign cross_a = {prod_a_xy[PW-1], prod_a_xy} - {prod_a_yx[PW-1], prod_a_yx};
	assign cross_b = {prod_b_xy[PW-1], prod_b_xy} - {prod_b_yx[PW-1], prod_b_yx};

	assign zero_a = (cross_a == '0);
	assign zero_b = (cross_b == '0);
	assign pos_a  = !cross_a[PW] && !zero_a;
	assign pos_b  = !cross_b[PW] && !zero_b;

	// endpoints on opposite sides of the line, or one lying on it
	assign hit = (pos_a != pos_b) || zero_a || zero_b;

endmodule

`default_nettype wire

// ===== rtl/core/profile_rect_crossing_check.sv =====
// an accepted item passes the input register and the product registers before
//   it is loaded into the result register
// throughput: one item per cycle; in_stall rises only when all three stages
//   hold items and the output is stalled
// the four sides are evaluated in parallel, one product multiplier each per term
// reset clears stage valids, the corner registers (to zero) and sets the running AND
`default_nettype none

module profile_rect_crossing_check #(
	parameter int COORD_WIDTH = 17
) (
	input  wire                                  clk,
	input  wire                                  arst_n,

	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [prcc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire  [COORD_WIDTH-1:0]               cfg_data,

	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [COORD_WIDTH-1:0]         seg_start_x,
	input  wire signed [COORD_WIDTH-1:0]         seg_start_y,
	input  wire signed [COORD_WIDTH-1:0]         seg_end_x,
	input  wire signed [COORD_WIDTH-1:0]         seg_end_y,
	input  wire                                  last_segment,

	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 segment_hit,
	output logic                                 all_hit,
	output logic                                 set_done
);
	import prcc_pkg::*;

	localparam int PW = 2 * (COORD_WIDTH + 1);

	cfg_wr_t                     cfg_wr;
	logic signed [COORD_WIDTH-1:0] corner_x [NUM_CORNERS];
	logic signed [COORD_WIDTH-1:0] corner_y [NUM_CORNERS];

	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;

	prcc_cfg_regs #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cfg_wr),
		.data     (cfg_data),
		.corner_x (corner_x),
		.corner_y (corner_y)
	);

	// pipeline control
	logic v_s1, v_s2, out_valid_q;
	logic stall_s2, stall_s3;
	logic load_s1, load_s2, load_s3;

	assign stall_s3 = out_valid_q && out_stall;
	assign stall_s2 = v_s2 && stall_s3;
	assign in_stall = v_s1 && stall_s2;
	assign load_s1  = in_valid && !in_stall;
	assign load_s2  = v_s1 && !stall_s2;
	assign load_s3  = v_s2 && !stall_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (!stall_s2) v_s2 <= v_s1;
			if (!stall_s3) out_valid_q <= v_s2;
		end
	end

	// input register
	logic signed [COORD_WIDTH-1:0] a_x_s1, a_y_s1, b_x_s1, b_y_s1;
	logic                          last_s1, last_s2;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			a_x_s1  <= seg_start_x;
			a_y_s1  <= seg_start_y;
			b_x_s1  <= seg_end_x;
			b_y_s1  <= seg_end_y;
			last_s1 <= last_segment;
		end
		if (load_s2) last_s2 <= last_s1;
	end

	// per side products, then signs
	logic signed [PW-1:0] pa_xy_s2 [NUM_CORNERS];
	logic signed [PW-1:0] pa_yx_s2 [NUM_CORNERS];
	logic signed [PW-1:0] pb_xy_s2 [NUM_CORNERS];
	logic signed [PW-1:0] pb_yx_s2 [NUM_CORNERS];
	logic [NUM_CORNERS-1:0] side_hit;

	for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_side
		prcc_side_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
			.clk          (clk),
			.load         (load_s2),
			.c_x          (corner_x[i]),
			.c_y          (corner_y[i]),
			.d_x          (corner_x[(i + 1) % NUM_CORNERS]),
			.d_y          (corner_y[(i + 1) % NUM_CORNERS]),
			.a_x          (a_x_s1),
			.a_y          (a_y_s1),
			.b_x          (b_x_s1),
			.b_y          (b_y_s1),
			.prod_a_xy_s2 (pa_xy_s2[i]),
			.prod_a_yx_s2 (pa_yx_s2[i]),
			.prod_b_xy_s2 (pb_xy_s2[i]),
			.prod_b_yx_s2 (pb_yx_s2[i])
		);

		prcc_side_sign #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
			.prod_a_xy (pa_xy_s2[i]),
			.prod_a_yx (pa_yx_s2[i]),
			.prod_b_xy (pb_xy_s2[i]),
			.prod_b_yx (pb_yx_s2[i]),
			.hit       (side_hit[i])
		);
	end

	// running AND over the set, updated as each item enters the output register
	logic running_all_q;
	logic seg_hit_s2, all_hit_s2;

	assign seg_hit_s2 = |side_hit;
	assign all_hit_s2 = running_all_q && seg_hit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_all_q <= 1'b1;
		end else if (load_s3) begin
			running_all_q <= last_s2 ? 1'b1 : all_hit_s2;
		end
	end

	logic seg_hit_q, all_hit_q, set_done_q;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			seg_hit_q  <= seg_hit_s2;
			all_hit_q  <= all_hit_s2;
			set_done_q <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign segment_hit = seg_hit_q;
	assign all_hit     = all_hit_q;
	assign set_done    = set_done_q;

`ifndef ASSERT_OFF
	a_and_cleared_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s3 && last_s2) |=> running_all_q)
		else $error("running AND not restored after last item of a set");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("input stalled while the pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> v_s1)
		else $error("accepted item missing from first stage");

	a_all_implies_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && all_hit) |-> segment_hit)
		else $error("all_hit set on a segment that missed");
`endif

endmodule

`default_nettype wire
